// ----- rtl/rmq_pkg.sv -----
// Shared widths, branch codes and the queued word type for the matrix-to-quaternion unit.
package rmq_pkg;

    localparam int SAMPLE_WIDTH = 16;
    localparam int FRAC_BITS    = 14;

    localparam int DW     = SAMPLE_WIDTH + 2;
    localparam int TW     = SAMPLE_WIDTH + 1;
    localparam int SQN    = (TW + FRAC_BITS + 1) / 2;
    localparam int RADW   = 2 * SQN;
    localparam int NW     = DW + FRAC_BITS;
    localparam int QW     = NW - FRAC_BITS - 1;
    localparam int DENW   = SQN + 1;
    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);

    localparam logic [1:0] BR_W = 2'd0;
    localparam logic [1:0] BR_X = 2'd1;
    localparam logic [1:0] BR_Y = 2'd2;
    localparam logic [1:0] BR_Z = 2'd3;

    typedef struct packed {
        logic [TW-1:0]        rad;
        logic signed [DW-1:0] d0;
        logic signed [DW-1:0] d1;
        logic signed [DW-1:0] d2;
        logic [1:0]           br;
    } t_item;

endpackage

// ----- rtl/rmq_front.sv -----
// Front stage: trace and diagonal test, radicand and off-diagonal sums and differences per branch.
module rmq_front import rmq_pkg::*; (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_push,
    output logic                           o_full,
    input  logic signed [SAMPLE_WIDTH-1:0] i_rot_00,
    input  logic signed [SAMPLE_WIDTH-1:0] i_rot_01,
    input  logic signed [SAMPLE_WIDTH-1:0] i_rot_02,
    input  logic signed [SAMPLE_WIDTH-1:0] i_rot_10,
    input  logic signed [SAMPLE_WIDTH-1:0] i_rot_11,
    input  logic signed [SAMPLE_WIDTH-1:0] i_rot_12,
    input  logic signed [SAMPLE_WIDTH-1:0] i_rot_20,
    input  logic signed [SAMPLE_WIDTH-1:0] i_rot_21,
    input  logic signed [SAMPLE_WIDTH-1:0] i_rot_22,
    output logic                           o_valid,
    output t_item                          o_item,
    input  logic                           i_ready
);

    localparam logic signed [DW-1:0] Q_ONE = DW'(2 ** FRAC_BITS);

    logic                 r_valid;
    t_item                r_item;
    t_item                n_item;
    logic                 accept;
    logic signed [DW-1:0] a00, a01, a02, a10, a11, a12, a20, a21, a22;
    logic signed [DW-1:0] tr, t;

    assign a00 = DW'(i_rot_00);
    assign a01 = DW'(i_rot_01);
    assign a02 = DW'(i_rot_02);
    assign a10 = DW'(i_rot_10);
    assign a11 = DW'(i_rot_11);
    assign a12 = DW'(i_rot_12);
    assign a20 = DW'(i_rot_20);
    assign a21 = DW'(i_rot_21);
    assign a22 = DW'(i_rot_22);
    assign tr  = a00 + a11 + a22;

    always_comb begin
        n_item = '0;
        if (tr > 0) begin
            n_item.br = BR_W;
            t         = tr + Q_ONE;
            n_item.d0 = a21 - a12;
            n_item.d1 = a02 - a20;
            n_item.d2 = a10 - a01;
        end else if (a00 > a11 && a00 > a22) begin
            n_item.br = BR_X;
            t         = Q_ONE + a00 - a11 - a22;
            n_item.d0 = a01 + a10;
            n_item.d1 = a02 + a20;
            n_item.d2 = a21 - a12;
        end else if (a11 > a22) begin
            n_item.br = BR_Y;
            t         = Q_ONE + a11 - a00 - a22;
            n_item.d0 = a01 + a10;
            n_item.d1 = a12 + a21;
            n_item.d2 = a02 - a20;
        end else begin
            n_item.br = BR_Z;
            t         = Q_ONE + a22 - a00 - a11;
            n_item.d0 = a02 + a20;
            n_item.d1 = a12 + a21;
            n_item.d2 = a10 - a01;
        end
        if (t < Q_ONE) begin
            t = Q_ONE;
        end
        n_item.rad = t[TW-1:0];
    end

    assign o_full  = r_valid && !i_ready;
    assign accept  = i_push && !o_full;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= accept || (r_valid && !i_ready);
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item <= n_item;
        end
    end

endmodule

// ----- rtl/rmq_fifo.sv -----
// Short queue between the front stage and the arithmetic pipeline.
module rmq_fifo import rmq_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    output logic  o_ready,
    input  t_item i_item,
    output logic  o_valid,
    output t_item o_item,
    input  logic  i_pop
);

    t_item          r_mem [0:QDEPTH-1];
    logic [QAW-1:0] r_wp, r_rp;
    logic [QAW:0]   r_cnt;
    logic           wr, rd;

    assign o_ready = r_cnt != (QAW+1)'(QDEPTH);
    assign o_valid = r_cnt != '0;
    assign o_item  = r_mem[r_rp];
    assign wr      = i_push && o_ready;
    assign rd      = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (wr) begin
                r_wp <= r_wp + 1'b1;
            end
            if (rd) begin
                r_rp <= r_rp + 1'b1;
            end
            if (wr && !rd) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (rd && !wr) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr) begin
            r_mem[r_wp] <= i_item;
        end
    end

endmodule

// ----- rtl/rmq_back.sv -----
// Back pipeline: bit-per-stage square root, three dividers, rounding, saturation, output register.
module rmq_back import rmq_pkg::*; (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    input  t_item                          i_item,
    output logic                           o_ready,
    input  logic                           i_pop,
    output logic                           o_empty,
    output logic signed [SAMPLE_WIDTH-1:0] o_quat_x,
    output logic signed [SAMPLE_WIDTH-1:0] o_quat_y,
    output logic signed [SAMPLE_WIDTH-1:0] o_quat_z,
    output logic signed [SAMPLE_WIDTH-1:0] o_quat_w
);

    localparam int RMW = SQN + 2;
    localparam logic signed [QW:0] VMAX = (QW+1)'(2 ** (SAMPLE_WIDTH - 1) - 1);
    localparam logic signed [QW:0] VMIN = -(QW+1)'(2 ** (SAMPLE_WIDTH - 1));

    function automatic logic signed [SAMPLE_WIDTH-1:0] sat_q(
        input logic [QW-1:0] q,
        input logic          neg
    );
        logic signed [QW:0] v;
        v = neg ? -$signed({1'b0, q}) : $signed({1'b0, q});
        if (v > VMAX) begin
            return SAMPLE_WIDTH'(VMAX);
        end else if (v < VMIN) begin
            return SAMPLE_WIDTH'(VMIN);
        end
        return SAMPLE_WIDTH'(v);
    endfunction

    logic adv;

    logic            r_sv    [0:SQN];
    logic [RADW-1:0] r_srad  [0:SQN];
    logic [RMW-1:0]  r_srem  [0:SQN];
    logic [SQN-1:0]  r_sroot [0:SQN];
    t_item           r_sit   [0:SQN];

    logic            r_dv    [0:QW];
    logic [DENW-1:0] r_dden  [0:QW];
    logic [SQN-1:0]  r_dhalf [0:QW];
    logic [1:0]      r_dbr   [0:QW];
    logic            r_dneg  [0:QW][0:2];
    logic [NW-1:0]   r_dnum  [0:QW][0:2];
    logic [DENW-1:0] r_drem  [0:QW][0:2];
    logic [QW-1:0]   r_dq    [0:QW][0:2];

    logic                           r_ov;
    logic signed [SAMPLE_WIDTH-1:0] r_qx, r_qy, r_qz, r_qw;

    assign adv     = !r_ov || i_pop;
    assign o_ready = adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sv[0] <= 1'b0;
        end else if (adv) begin
            r_sv[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_srad[0]  <= RADW'({i_item.rad, {FRAC_BITS{1'b0}}});
            r_srem[0]  <= '0;
            r_sroot[0] <= '0;
            r_sit[0]   <= i_item;
        end
    end

    for (genvar k = 0; k < SQN; k++) begin : g_sqrt
        logic [RMW+1:0] cur, trial;
        logic           ge;
        assign cur   = {r_srem[k], r_srad[k][2*(SQN-1-k) +: 2]};
        assign trial = (RMW+2)'({r_sroot[k], 2'b01});
        assign ge    = cur >= trial;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sv[k+1] <= 1'b0;
            end else if (adv) begin
                r_sv[k+1] <= r_sv[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (adv) begin
                r_srad[k+1]  <= r_srad[k];
                r_sit[k+1]   <= r_sit[k];
                r_srem[k+1]  <= ge ? RMW'(cur - trial) : RMW'(cur);
                r_sroot[k+1] <= {r_sroot[k][SQN-2:0], ge};
            end
        end
    end

    logic [SQN-1:0]       s;
    logic [SQN:0]         s_inc;
    logic signed [DW-1:0] dsel [0:2];

    assign s       = r_sroot[SQN];
    assign s_inc   = {1'b0, s} + 1'b1;
    assign dsel[0] = r_sit[SQN].d0;
    assign dsel[1] = r_sit[SQN].d1;
    assign dsel[2] = r_sit[SQN].d2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv[0] <= 1'b0;
        end else if (adv) begin
            r_dv[0] <= r_sv[SQN];
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_dden[0]  <= {s, 1'b0};
            r_dhalf[0] <= s_inc[SQN:1];
            r_dbr[0]   <= r_sit[SQN].br;
        end
    end

    for (genvar l = 0; l < 3; l++) begin : g_lane
        logic [DW-1:0] mag;
        logic [NW-1:0] num;
        assign mag = dsel[l] < 0 ? DW'(-dsel[l]) : DW'(dsel[l]);
        assign num = NW'({mag[DW-2:0], {FRAC_BITS{1'b0}}}) + NW'(s);

        always_ff @(posedge i_clk) begin
            if (adv) begin
                r_dneg[0][l] <= dsel[l] < 0;
                r_dnum[0][l] <= num;
                r_drem[0][l] <= DENW'(num[NW-1:QW]);
                r_dq[0][l]   <= '0;
            end
        end
    end

    for (genvar k = 0; k < QW; k++) begin : g_div
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv[k+1] <= 1'b0;
            end else if (adv) begin
                r_dv[k+1] <= r_dv[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (adv) begin
                r_dden[k+1]  <= r_dden[k];
                r_dhalf[k+1] <= r_dhalf[k];
                r_dbr[k+1]   <= r_dbr[k];
            end
        end

        for (genvar l = 0; l < 3; l++) begin : g_dl
            logic [DENW:0] cur;
            logic          ge;
            assign cur = {r_drem[k][l], r_dnum[k][l][QW-1-k]};
            assign ge  = cur >= {1'b0, r_dden[k]};

            always_ff @(posedge i_clk) begin
                if (adv) begin
                    r_dneg[k+1][l] <= r_dneg[k][l];
                    r_dnum[k+1][l] <= r_dnum[k][l];
                    r_drem[k+1][l] <= ge ? DENW'(cur - {1'b0, r_dden[k]}) : DENW'(cur);
                    r_dq[k+1][l]   <= {r_dq[k][l][QW-2:0], ge};
                end
            end
        end
    end

    logic signed [SAMPLE_WIDTH-1:0] v0, v1, v2, vh;
    logic signed [SAMPLE_WIDTH-1:0] n_qx, n_qy, n_qz, n_qw;

    assign v0 = sat_q(r_dq[QW][0], r_dneg[QW][0]);
    assign v1 = sat_q(r_dq[QW][1], r_dneg[QW][1]);
    assign v2 = sat_q(r_dq[QW][2], r_dneg[QW][2]);
    assign vh = SAMPLE_WIDTH'(r_dhalf[QW]);

    always_comb begin
        case (r_dbr[QW])
            BR_W: begin
                n_qx = v0; n_qy = v1; n_qz = v2; n_qw = vh;
            end
            BR_X: begin
                n_qx = vh; n_qy = v0; n_qz = v1; n_qw = v2;
            end
            BR_Y: begin
                n_qx = v0; n_qy = vh; n_qz = v1; n_qw = v2;
            end
            BR_Z: begin
                n_qx = v0; n_qy = v1; n_qz = vh; n_qw = v2;
            end
            default: begin
                n_qx = v0; n_qy = v1; n_qz = v2; n_qw = vh;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (adv) begin
            r_ov <= r_dv[QW];
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_qx <= n_qx;
            r_qy <= n_qy;
            r_qz <= n_qz;
            r_qw <= n_qw;
        end
    end

    assign o_empty  = !r_ov;
    assign o_quat_x = r_qx;
    assign o_quat_y = r_qy;
    assign o_quat_z = r_qz;
    assign o_quat_w = r_qw;

endmodule

// ----- rtl/rotation_matrix_to_quaternion_unit.sv -----
// Top level: rotation matrix to unit quaternion, Shepperd branch selection, Q1.14.
// Throughput: one word per cycle while the output register is not held; 16-stage root and 17-stage divide pipelines.
// The arithmetic pipeline stalls as a whole only while the output register is held.
// Reset: synchronous, active low; clears all valid flags and the queue, no clearing pass.
module rotation_matrix_to_quaternion_unit import rmq_pkg::*; (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           push,
    output logic                           full,
    input  logic signed [SAMPLE_WIDTH-1:0] i_rot_00,
    input  logic signed [SAMPLE_WIDTH-1:0] i_rot_01,
    input  logic signed [SAMPLE_WIDTH-1:0] i_rot_02,
    input  logic signed [SAMPLE_WIDTH-1:0] i_rot_10,
    input  logic signed [SAMPLE_WIDTH-1:0] i_rot_11,
    input  logic signed [SAMPLE_WIDTH-1:0] i_rot_12,
    input  logic signed [SAMPLE_WIDTH-1:0] i_rot_20,
    input  logic signed [SAMPLE_WIDTH-1:0] i_rot_21,
    input  logic signed [SAMPLE_WIDTH-1:0] i_rot_22,
    output logic                           empty,
    input  logic                           pop,
    output logic signed [SAMPLE_WIDTH-1:0] o_quat_x,
    output logic signed [SAMPLE_WIDTH-1:0] o_quat_y,
    output logic signed [SAMPLE_WIDTH-1:0] o_quat_z,
    output logic signed [SAMPLE_WIDTH-1:0] o_quat_w
);

    logic  fr_valid, fq_ready, fq_valid, bk_ready;
    t_item fr_item, fq_item;

    rmq_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .o_full   (full),
        .i_rot_00 (i_rot_00),
        .i_rot_01 (i_rot_01),
        .i_rot_02 (i_rot_02),
        .i_rot_10 (i_rot_10),
        .i_rot_11 (i_rot_11),
        .i_rot_12 (i_rot_12),
        .i_rot_20 (i_rot_20),
        .i_rot_21 (i_rot_21),
        .i_rot_22 (i_rot_22),
        .o_valid  (fr_valid),
        .o_item   (fr_item),
        .i_ready  (fq_ready)
    );

    rmq_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (fr_valid),
        .o_ready (fq_ready),
        .i_item  (fr_item),
        .o_valid (fq_valid),
        .o_item  (fq_item),
        .i_pop   (bk_ready)
    );

    rmq_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (fq_valid),
        .i_item   (fq_item),
        .o_ready  (bk_ready),
        .i_pop    (pop),
        .o_empty  (empty),
        .o_quat_x (o_quat_x),
        .o_quat_y (o_quat_y),
        .o_quat_z (o_quat_z),
        .o_quat_w (o_quat_w)
    );

    a_fifo_full_has_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !fq_ready |-> fq_valid)
        else $error("queue reports full with no data");

    a_one_large_component: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (o_quat_x >= 16'sd8192 || o_quat_y >= 16'sd8192 ||
                    o_quat_z >= 16'sd8192 || o_quat_w >= 16'sd8192))
        else $error("result lacks the selected component");

    a_reset_clears: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> (empty && !full))
        else $error("control state not cleared by reset");

endmodule
